// File: rtl/cdth_pkg.sv
package cdth_pkg;

  // Coordinate width on the input channel
  localparam int COORD_BITS = 16;

  // Stream widths, padded to whole bytes
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 17 + 1 + 1 + 18;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  // Hash mixing constants
  localparam logic [31:0] MIX_COL    = 32'h9E37_79B1;
  localparam logic [31:0] MIX_ROW    = 32'h85EB_CA6B;
  localparam logic [31:0] MIX_A      = 32'h2C1B_3C6D;
  localparam logic [31:0] MIX_B      = 32'h297A_2D39;
  localparam logic [31:0] SALT_THR   = 32'hA5A5_A5A5;
  localparam logic [31:0] SALT_SHIFT = 32'h5F35_6495;

  // Level full scale (1.0 in units of 1/100000)
  localparam logic [16:0] ALPHA_FULL = 17'd100000;

  // Threshold modulo: 100000 = 32 * 3125, reduce h >> 5 by 3125
  localparam logic [11:0] THR_DIV    = 12'd3125;
  localparam logic [20:0] THR_RECIP  = 21'd1374389;   // floor(2^32 / 3125)

  // Shift modulo 200001
  localparam logic [17:0] SHIFT_DIV   = 18'd200001;
  localparam logic [14:0] SHIFT_RECIP = 15'd21474;    // floor(2^32 / 200001)

  // Configuration register indexes
  localparam int          CFG_IDX_W = 2;
  localparam logic [1:0]  REG_ALPHA = 2'd0;
  localparam logic [1:0]  REG_BAND  = 2'd1;

  typedef struct packed {
    logic [31:0] thr_hash;
    logic [31:0] shift_hash;
  } hash_pair_t;

  function automatic logic [16:0] sat_level(input logic [16:0] v);
    return (v > ALPHA_FULL) ? ALPHA_FULL : v;
  endfunction

endpackage

// File: rtl/cdth_hash_pipe.sv
module cdth_hash_pipe (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cdth_pkg::COORD_BITS-1:0] cell_col,
  input  logic signed [cdth_pkg::COORD_BITS-1:0] cell_row,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output cdth_pkg::hash_pair_t                   out_hash
);

  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;

  logic [31:0] col_ext, row_ext;
  logic [31:0] pc_nxt, pr_nxt, pc_r, pr_r;
  logic [31:0] base, ht0, hs0, ht1, hs1;
  logic [31:0] mt_nxt, ms_nxt, mt_r, ms_r;
  logic [31:0] ht2, hs2;
  logic [31:0] nt_nxt, ns_nxt, nt_r, ns_r;

  // Stall control: a stage loads when it is empty or its successor loads
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: sign-extend, multiply each coordinate
  assign col_ext = 32'(cell_col);
  assign row_ext = 32'(cell_row);
  assign pc_nxt  = col_ext * cdth_pkg::MIX_COL;
  assign pr_nxt  = row_ext * cdth_pkg::MIX_ROW;

  // Stage 2: combine with salts, xorshift 15, multiply
  assign base   = pc_r ^ pr_r;
  assign ht0    = base ^ cdth_pkg::SALT_THR;
  assign hs0    = base ^ cdth_pkg::SALT_SHIFT;
  assign ht1    = ht0 ^ (ht0 >> 15);
  assign hs1    = hs0 ^ (hs0 >> 15);
  assign mt_nxt = ht1 * cdth_pkg::MIX_A;
  assign ms_nxt = hs1 * cdth_pkg::MIX_A;

  // Stage 3: xorshift 12, multiply
  assign ht2    = mt_r ^ (mt_r >> 12);
  assign hs2    = ms_r ^ (ms_r >> 12);
  assign nt_nxt = ht2 * cdth_pkg::MIX_B;
  assign ns_nxt = hs2 * cdth_pkg::MIX_B;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pc_r <= pc_nxt;
      pr_r <= pr_nxt;
    end
    if (en2) begin
      mt_r <= mt_nxt;
      ms_r <= ms_nxt;
    end
    if (en3) begin
      nt_r <= nt_nxt;
      ns_r <= ns_nxt;
    end
  end

  // Final xorshift 15 on the registered products
  assign out_valid           = v3_r;
  assign out_hash.thr_hash   = nt_r ^ (nt_r >> 15);
  assign out_hash.shift_hash = ns_r ^ (ns_r >> 15);

endmodule

// File: rtl/cell_dissolve_threshold_hash_unit.sv
// Pipeline: 3 hash stages, 3 modulo stages, 1 compare/output stage.
// Throughput: one cell per cycle unless the output stalls; every stage holds its
//   own valid bit and fills bubbles while the output is stalled.
// Reset (rst_n low, synchronous): empties the pipeline and clears alpha_level
//   and band_width to 0. Configuration writes are always ready.
module cell_dissolve_threshold_hash_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  // Cell stream in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cdth_pkg::IN_W-1:0]         in_tdata,   // cell_col, cell_row

  // Result stream out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cdth_pkg::OUT_W-1:0]        out_tdata,  // threshold_code[16:0],
                                                        // block_on, on_wavefront,
                                                        // shift_code[17:0], zero pad

  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdth_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [16:0]                       cfg_data
);

  localparam int CB = cdth_pkg::COORD_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers, saturated to full scale on write
  // ---------------------------------------------------------------------------
  logic [16:0] alpha_r, band_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      band_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdth_pkg::REG_ALPHA: alpha_r <= cdth_pkg::sat_level(cfg_data);
        cdth_pkg::REG_BAND:  band_r  <= cdth_pkg::sat_level(cfg_data);
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Hash front end: three multiply stages
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] cell_col, cell_row;
  logic                 h_valid, h_ready;
  cdth_pkg::hash_pair_t h_pair;

  assign cell_col = in_tdata[CB-1:0];
  assign cell_row = in_tdata[2*CB-1:CB];

  cdth_hash_pipe u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .out_valid (h_valid),
    .out_ready (h_ready),
    .out_hash  (h_pair)
  );

  // ---------------------------------------------------------------------------
  // Stall control for the back end
  // ---------------------------------------------------------------------------
  logic va_r, vb_r, vc_r, vd_r;
  logic ena, enb, enc, end_en;

  assign end_en  = !vd_r || out_tready;
  assign enc     = !vc_r || end_en;
  assign enb     = !vb_r || enc;
  assign ena     = !va_r || enb;
  assign h_ready = ena;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ena)    va_r <= h_valid;
      if (enb)    vb_r <= va_r;
      if (enc)    vc_r <= vb_r;
      if (end_en) vd_r <= vc_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: quotient estimates by reciprocal multiply (low by at most one).
  // Threshold: h mod 100000 = ((h >> 5) mod 3125) * 32 + h[4:0].
  // ---------------------------------------------------------------------------
  logic [26:0] xt;
  logic [47:0] prod_t;
  logic [46:0] prod_s;
  logic [15:0] qt_nxt, qt_r;
  logic [14:0] qs_nxt, qs_r;
  logic [26:0] xt_r;
  logic [4:0]  lo_a_r;
  logic [31:0] hs_r;

  assign xt     = h_pair.thr_hash[31:5];
  assign prod_t = 48'(xt) * 48'(cdth_pkg::THR_RECIP);
  assign prod_s = 47'(h_pair.shift_hash) * 47'(cdth_pkg::SHIFT_RECIP);
  assign qt_nxt = prod_t[47:32];
  assign qs_nxt = prod_s[46:32];

  always_ff @(posedge clk) begin
    if (ena) begin
      qt_r   <= qt_nxt;
      qs_r   <= qs_nxt;
      xt_r   <= xt;
      lo_a_r <= h_pair.thr_hash[4:0];
      hs_r   <= h_pair.shift_hash;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: partial remainders, each below twice its divisor
  // ---------------------------------------------------------------------------
  logic [26:0] mt, dt;
  logic [31:0] ms, ds;
  logic [12:0] dt_nxt, dt_r;
  logic [18:0] ds_nxt, ds_r;
  logic [4:0]  lo_b_r;

  assign mt     = 27'(qt_r) * 27'(cdth_pkg::THR_DIV);
  assign dt     = xt_r - mt;
  assign ms     = 32'(qs_r) * 32'(cdth_pkg::SHIFT_DIV);
  assign ds     = hs_r - ms;
  assign dt_nxt = dt[12:0];
  assign ds_nxt = ds[18:0];

  always_ff @(posedge clk) begin
    if (enb) begin
      dt_r   <= dt_nxt;
      ds_r   <= ds_nxt;
      lo_b_r <= lo_a_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: one conditional subtract finishes each modulo
  // ---------------------------------------------------------------------------
  logic [12:0] rt;
  logic [18:0] rs;
  logic [16:0] thr_nxt, thr_r;
  logic [17:0] shift_nxt, shift_c_r;

  assign rt = (dt_r >= 13'(cdth_pkg::THR_DIV)) ? dt_r - 13'(cdth_pkg::THR_DIV) : dt_r;
  assign rs = (ds_r >= 19'(cdth_pkg::SHIFT_DIV)) ? ds_r - 19'(cdth_pkg::SHIFT_DIV) : ds_r;
  assign thr_nxt   = {rt[11:0], lo_b_r};
  assign shift_nxt = rs[17:0];

  always_ff @(posedge clk) begin
    if (enc) begin
      thr_r     <= thr_nxt;
      shift_c_r <= shift_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: level compares into the output register
  // ---------------------------------------------------------------------------
  logic        a_zero, a_full, a_ge;
  logic [16:0] a_diff;
  logic        on_nxt, wave_nxt;
  logic        on_r, wave_r;
  logic [16:0] thr_d_r;
  logic [17:0] shift_d_r;

  assign a_zero   = (alpha_r == '0);
  assign a_full   = (alpha_r >= cdth_pkg::ALPHA_FULL);
  assign a_ge     = (alpha_r >= thr_r);
  assign a_diff   = alpha_r - thr_r;
  assign on_nxt   = !a_zero && (a_full || a_ge);
  assign wave_nxt = !a_zero && !a_full && (band_r != '0) && a_ge && (a_diff <= band_r);

  always_ff @(posedge clk) begin
    if (end_en) begin
      thr_d_r   <= thr_r;
      shift_d_r <= shift_c_r;
      on_r      <= on_nxt;
      wave_r    <= wave_nxt;
    end
  end

  assign out_tvalid = vd_r;
  assign out_tdata  = {(cdth_pkg::OUT_W - cdth_pkg::OUT_RAW_W)'(0),
                       shift_d_r, wave_r, on_r, thr_d_r};

endmodule
